// File: rtl/multitrack_audio_looper_defines.svh
// assertion macros for the multitrack looper
// no dependencies; included by the top level
`ifndef MULTITRACK_AUDIO_LOOPER_DEFINES_SVH
`define MULTITRACK_AUDIO_LOOPER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MAL_CHK_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("looper check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define MAL_CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("looper check failed");

`endif

// File: rtl/mal_pkg.sv
// shared types and codes of the multitrack looper
// no dependencies
`default_nettype none

package mal_pkg;

    localparam int SAMPLE_W = 24;
    localparam int TIDX_W   = 20;
    localparam int LEN_W    = 19;

    localparam logic [2:0] FN_SAMPLE    = 3'd0;
    localparam logic [2:0] FN_ADD       = 3'd1;
    localparam logic [2:0] FN_RECORD    = 3'd2;
    localparam logic [2:0] FN_STOP_REC  = 3'd3;
    localparam logic [2:0] FN_PLAY      = 3'd4;
    localparam logic [2:0] FN_STOP_PLAY = 3'd5;
    localparam logic [2:0] FN_CLEAR     = 3'd6;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_STOPPED = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CMD,
        S_REC,
        S_REC_DIV,
        S_REC_WR,
        S_PLAY,
        S_PLAY_DIV,
        S_PLAY_ACC,
        S_MIX,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/multitrack_audio_looper.sv
// stereo multitrack looper: top level with the audio store and the track sequencer
// depends on mal_pkg and multitrack_audio_looper_defines.svh
`default_nettype none
`include "multitrack_audio_looper_defines.svh"

// usage
// - input stream: one transfer per item; tuser carries the function code, tdata the track,
//   stereo sample and trigger; a function of zero is an audio sample, the rest are commands
// - output stream: exactly one transfer per input item, in order; tdata carries the mixed
//   stereo sample and the master loop length, tuser the record event
// - a sample walks every track twice through the audio store: a write pass for the
//   recording tracks, then a read pass for the playing ones; each position that reaches
//   or runs past the loop length is folded by the serial remainder unit
// - add, record and clear also wipe the track store, one entry per cycle, MAX_SAMPLES
//   rounded up to a power of two entries
// - after reset the whole store is wiped, TRACKS * 2**clog2(MAX_SAMPLES) entries, with
//   s_axis_tready low throughout
// - the result sits in an output register: a stalled receiver holds it, the next item is
//   still taken and worked on, and only its result waits until the register frees
module multitrack_audio_looper
    import mal_pkg::*;
#(
    parameter int TRACKS      = 8,
    parameter int MAX_SAMPLES = 262144
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // track[2:0], in_left[26:3], in_right[50:27], trigger_valid[51], trigger_index[71:52]
    input  wire logic [71:0] s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_left[23:0], out_right[47:24], loop_length[66:48], zero[71:67]
    output logic [71:0]      m_axis_tdata,
    // event_res[1:0]
    output logic [1:0]       m_axis_tuser
);

    localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int PW    = $clog2(MAX_SAMPLES + 1);
    localparam int MA    = TW + AW;
    localparam int DEPTH = TRACKS * (2 ** AW);
    localparam int CW    = $clog2(PW + 1);
    localparam int SW    = SAMPLE_W + $clog2(TRACKS + 1);

    localparam logic [MA-1:0] LAST_ADDR = MA'(DEPTH - 1);
    localparam logic [PW-1:0] MAX_P     = PW'(MAX_SAMPLES);
    localparam logic [PW-1:0] MAXM1_P   = PW'(MAX_SAMPLES - 1);
    localparam logic [TW-1:0] TLAST     = TW'(TRACKS - 1);
    localparam logic [CW-1:0] DV_LAST   = CW'(PW - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(8388607);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(8388608);

    // audio store, {right, left} per entry
    logic [2*SAMPLE_W-1:0] r_mem [DEPTH];
    logic [2*SAMPLE_W-1:0] r_rd_data;

    t_state r_state, n_state;

    // latched item
    logic [2:0]                 r_func, n_func;
    logic [2:0]                 r_t, n_t;
    logic signed [SAMPLE_W-1:0] r_il, n_il, r_ir, n_ir;
    logic                       r_trig, n_trig;
    logic [TIDX_W-1:0]          r_tidx, n_tidx;

    // track state
    logic [TRACKS-1:0] r_present, n_present, r_rec, n_rec, r_play, n_play;
    logic [PW-1:0]     r_wp [TRACKS];
    logic [PW-1:0]     n_wp [TRACKS];
    logic [PW-1:0]     r_rp [TRACKS];
    logic [PW-1:0]     n_rp [TRACKS];
    logic [PW-1:0]     r_rc [TRACKS];
    logic [PW-1:0]     n_rc [TRACKS];
    logic [PW-1:0]     r_ml, n_ml, r_mpos, n_mpos;
    logic [TW-1:0]     r_mt, n_mt;

    // sequencer
    logic [TW-1:0]          r_k, n_k;
    logic [PW-1:0]          r_pos, n_pos;
    logic signed [SW-1:0]   r_sl, n_sl, r_sr, n_sr;
    logic [1:0]             r_ev, n_ev;
    logic [PW-1:0]          r_dv_num, n_dv_num, r_dv_den, n_dv_den, r_dv_rem, n_dv_rem;
    logic [CW-1:0]          r_dv_cnt, n_dv_cnt;
    logic [MA-1:0]          r_clr_addr, n_clr_addr, r_clr_last, n_clr_last;
    logic                   r_clr_cmd, n_clr_cmd;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, n_out_l, r_out_r, n_out_r;
    logic [1:0]                 r_out_ev, n_out_ev;
    logic [LEN_W-1:0]           r_out_len, n_out_len;

    // store port
    logic                  c_we, c_re;
    logic [MA-1:0]         c_waddr, c_raddr;
    logic [2*SAMPLE_W-1:0] c_wdata;

    // serial remainder step
    logic [PW:0]   c_dv_sh;
    logic [PW-1:0] c_dv_rem;

    // stop-record evaluation
    logic [PW-1:0] c_st_wp, c_st_rc, c_st_rc_out;
    logic          c_st_ok, c_st_set_ml;

    // misc
    logic [TW-1:0]         c_ti;
    logic [PW-1:0]         c_tclamp, c_wp_new, c_rc_new, c_len, c_nxt;
    logic                  c_wr_ok;
    logic [SAMPLE_W-1:0]   c_sat_l, c_sat_r;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_len, r_out_r, r_out_l};
    assign m_axis_tuser  = r_out_ev;

    assign c_dv_sh  = {r_dv_rem, r_dv_num[PW-1]};
    assign c_dv_rem = (c_dv_sh >= {1'b0, r_dv_den}) ? PW'(c_dv_sh - {1'b0, r_dv_den})
                                                    : PW'(c_dv_sh);

    assign c_tclamp = ({1'b0, r_tidx} > 21'(MAX_SAMPLES - 1)) ? MAXM1_P : PW'(r_tidx);

    always_comb begin
        if (r_sl > SAT_HI) begin
            c_sat_l = 24'h7FFFFF;
        end else if (r_sl < SAT_LO) begin
            c_sat_l = 24'h800000;
        end else begin
            c_sat_l = r_sl[SAMPLE_W-1:0];
        end
        if (r_sr > SAT_HI) begin
            c_sat_r = 24'h7FFFFF;
        end else if (r_sr < SAT_LO) begin
            c_sat_r = 24'h800000;
        end else begin
            c_sat_r = r_sr[SAMPLE_W-1:0];
        end
    end

    // stop-record outcome for the selected track
    always_comb begin
        c_st_ok     = 1'b0;
        c_st_set_ml = 1'b0;
        c_st_rc_out = c_st_rc;
        if (r_ml == '0) begin
            if (c_st_wp != '0) begin
                c_st_ok     = 1'b1;
                c_st_set_ml = 1'b1;
                c_st_rc_out = c_st_wp;
            end
        end else if (!(c_st_wp == '0 && c_st_rc == '0)) begin
            c_st_ok     = 1'b1;
            c_st_rc_out = (c_st_wp < r_ml) ? c_st_wp : r_ml;
        end
    end

    assign c_ti = (r_state == S_CMD) ? TW'(r_t) : r_k;

    // write-pass arithmetic on the folded position, and the read-pass length and next position
    always_comb begin
        c_wr_ok  = 1'b1;
        c_wp_new = r_pos;
        if (r_ml != '0) begin
            c_wp_new = (PW'(r_pos + 1'b1) == r_ml) ? '0 : PW'(r_pos + 1'b1);
        end else if (r_pos < MAX_P) begin
            c_wp_new = PW'(r_pos + 1'b1);
        end else begin
            c_wr_ok = 1'b0;
        end
        c_rc_new = PW'(r_rc[r_k] + 1'b1);
        c_len    = (r_ml != '0) ? r_ml : ((r_rc[r_k] != '0) ? r_rc[r_k] : MAX_P);
        c_nxt    = PW'(r_rp[r_k] + 1'b1);
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_t         = r_t;
        n_il        = r_il;
        n_ir        = r_ir;
        n_trig      = r_trig;
        n_tidx      = r_tidx;
        n_present   = r_present;
        n_rec       = r_rec;
        n_play      = r_play;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_rc        = r_rc;
        n_ml        = r_ml;
        n_mpos      = r_mpos;
        n_mt        = r_mt;
        n_k         = r_k;
        n_pos       = r_pos;
        n_sl        = r_sl;
        n_sr        = r_sr;
        n_ev        = r_ev;
        n_dv_num    = r_dv_num;
        n_dv_den    = r_dv_den;
        n_dv_rem    = r_dv_rem;
        n_dv_cnt    = r_dv_cnt;
        n_clr_addr  = r_clr_addr;
        n_clr_last  = r_clr_last;
        n_clr_cmd   = r_clr_cmd;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_ev    = r_out_ev;
        n_out_len   = r_out_len;
        c_we        = 1'b0;
        c_waddr     = r_clr_addr;
        c_wdata     = '0;
        c_re        = 1'b0;
        c_raddr     = {r_k, r_rp[r_k][AW-1:0]};
        c_st_wp     = r_wp[c_ti];
        c_st_rc     = r_rc[c_ti];

        unique case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
                if (r_clr_addr == r_clr_last) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end else begin
                    n_clr_addr = MA'(r_clr_addr + 1'b1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func  = s_axis_tuser;
                    n_t     = s_axis_tdata[2:0];
                    n_il    = s_axis_tdata[26:3];
                    n_ir    = s_axis_tdata[50:27];
                    n_trig  = s_axis_tdata[51];
                    n_tidx  = s_axis_tdata[71:52];
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                n_sl    = '0;
                n_sr    = '0;
                n_ev    = EV_NONE;
                n_k     = '0;
                n_state = S_DONE;
                if (r_func == FN_SAMPLE) begin
                    n_sl    = SW'(r_il);
                    n_sr    = SW'(r_ir);
                    n_state = S_REC;
                end else if (int'(r_t) < TRACKS) begin
                    if (r_func == FN_ADD) begin
                        n_present[c_ti] = 1'b1;
                        n_rec[c_ti]     = 1'b0;
                        n_play[c_ti]    = 1'b0;
                        n_wp[c_ti]      = '0;
                        n_rp[c_ti]      = '0;
                        n_rc[c_ti]      = '0;
                        n_clr_addr      = {c_ti, {AW{1'b0}}};
                        n_clr_last      = {c_ti, {AW{1'b1}}};
                        n_clr_cmd       = 1'b1;
                        n_state         = S_CLEAR;
                    end else if (r_present[c_ti]) begin
                        unique case (r_func)
                            FN_RECORD: begin
                                n_rec[c_ti]  = 1'b1;
                                n_play[c_ti] = 1'b0;
                                n_rc[c_ti]   = '0;
                                // the track itself stops playing and is never taken as the master for alignment
                                if (r_ml != '0 && r_mt != c_ti && r_present[r_mt] &&
                                    r_play[r_mt]) begin
                                    n_wp[c_ti] = r_mpos;
                                end else if (r_trig) begin
                                    n_wp[c_ti] = c_tclamp;
                                end else begin
                                    n_rp[c_ti] = '0;
                                    n_wp[c_ti] = '0;
                                end
                                n_ev       = EV_STARTED;
                                n_clr_addr = {c_ti, {AW{1'b0}}};
                                n_clr_last = {c_ti, {AW{1'b1}}};
                                n_clr_cmd  = 1'b1;
                                n_state    = S_CLEAR;
                            end
                            FN_STOP_REC: begin
                                if (r_rec[c_ti]) begin
                                    n_rec[c_ti] = 1'b0;
                                    if (c_st_set_ml) begin
                                        n_ml = c_st_wp;
                                        n_mt = c_ti;
                                    end
                                    if (c_st_ok) begin
                                        n_rc[c_ti] = c_st_rc_out;
                                        n_ev       = EV_STOPPED;
                                    end
                                end
                            end
                            FN_PLAY: begin
                                n_play[c_ti] = 1'b1;
                                n_rp[c_ti]   = (r_ml != '0) ? r_mpos : '0;
                            end
                            FN_STOP_PLAY: begin
                                n_play[c_ti] = 1'b0;
                            end
                            FN_CLEAR: begin
                                n_clr_addr = {c_ti, {AW{1'b0}}};
                                n_clr_last = {c_ti, {AW{1'b1}}};
                                n_clr_cmd  = 1'b1;
                                n_state    = S_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_REC: begin
                if (r_present[r_k] && r_rec[r_k]) begin
                    if (r_ml != '0 && r_wp[r_k] >= r_ml) begin
                        n_dv_num = r_wp[r_k];
                        n_dv_den = r_ml;
                        n_dv_rem = '0;
                        n_dv_cnt = '0;
                        n_state  = S_REC_DIV;
                    end else begin
                        n_pos   = r_wp[r_k];
                        n_state = S_REC_WR;
                    end
                end else if (r_k == TLAST) begin
                    n_k     = '0;
                    n_state = S_PLAY;
                end else begin
                    n_k = TW'(r_k + 1'b1);
                end
            end
            S_REC_DIV, S_PLAY_DIV: begin
                n_dv_rem = c_dv_rem;
                n_dv_num = PW'({r_dv_num, 1'b0});
                n_dv_cnt = CW'(r_dv_cnt + 1'b1);
                if (r_dv_cnt == DV_LAST) begin
                    n_pos   = c_dv_rem;
                    n_state = (r_state == S_REC_DIV) ? S_REC_WR : S_PLAY_ACC;
                end
            end
            S_REC_WR: begin
                c_we       = c_wr_ok;
                c_waddr    = {r_k, r_pos[AW-1:0]};
                c_wdata    = {r_ir, r_il};
                n_wp[r_k]  = c_wp_new;
                n_rc[r_k]  = c_rc_new;
                c_st_wp    = c_wp_new;
                c_st_rc    = c_rc_new;
                // loop length hit: stop recording, play from a prior master position or zero
                if (c_rc_new >= ((r_ml != '0) ? r_ml : MAX_P)) begin
                    n_rec[r_k] = 1'b0;
                    if (c_st_set_ml) begin
                        n_ml = c_wp_new;
                        n_mt = r_k;
                    end
                    if (c_st_ok) begin
                        n_rc[r_k] = c_st_rc_out;
                        n_ev      = EV_STOPPED;
                    end
                    n_play[r_k] = 1'b1;
                    n_rp[r_k]   = (c_st_set_ml || r_ml == '0) ? '0 : r_mpos;
                end
                if (r_k == TLAST) begin
                    n_k     = '0;
                    n_state = S_PLAY;
                end else begin
                    n_k     = TW'(r_k + 1'b1);
                    n_state = S_REC;
                end
            end
            S_PLAY: begin
                if (r_present[r_k] && r_play[r_k]) begin
                    c_re = 1'b1;
                    if (c_nxt >= c_len) begin
                        n_dv_num = c_nxt;
                        n_dv_den = c_len;
                        n_dv_rem = '0;
                        n_dv_cnt = '0;
                        n_state  = S_PLAY_DIV;
                    end else begin
                        n_pos   = c_nxt;
                        n_state = S_PLAY_ACC;
                    end
                end else if (r_k == TLAST) begin
                    n_state = S_MIX;
                end else begin
                    n_k = TW'(r_k + 1'b1);
                end
            end
            S_PLAY_ACC: begin
                n_sl      = r_sl + SW'(signed'(r_rd_data[SAMPLE_W-1:0]));
                n_sr      = r_sr + SW'(signed'(r_rd_data[2*SAMPLE_W-1:SAMPLE_W]));
                n_rp[r_k] = r_pos;
                if (r_k == TLAST) begin
                    n_state = S_MIX;
                end else begin
                    n_k     = TW'(r_k + 1'b1);
                    n_state = S_PLAY;
                end
            end
            S_MIX: begin
                if (r_ml != '0) begin
                    n_mpos = (PW'(r_mpos + 1'b1) == r_ml) ? '0 : PW'(r_mpos + 1'b1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_l     = c_sat_l;
                    n_out_r     = c_sat_r;
                    n_out_ev    = r_ev;
                    n_out_len   = LEN_W'(r_ml);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // audio store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_rd_data <= r_mem[c_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_last  <= LAST_ADDR;
            r_clr_cmd   <= 1'b0;
            r_present   <= '0;
            r_rec       <= '0;
            r_play      <= '0;
            r_ml        <= '0;
            r_mpos      <= '0;
            r_mt        <= '0;
            r_k         <= '0;
            r_dv_cnt    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TRACKS; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
                r_rc[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_last  <= n_clr_last;
            r_clr_cmd   <= n_clr_cmd;
            r_present   <= n_present;
            r_rec       <= n_rec;
            r_play      <= n_play;
            r_ml        <= n_ml;
            r_mpos      <= n_mpos;
            r_mt        <= n_mt;
            r_k         <= n_k;
            r_dv_cnt    <= n_dv_cnt;
            r_out_valid <= n_out_valid;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_rc        <= n_rc;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_t       <= n_t;
        r_il      <= n_il;
        r_ir      <= n_ir;
        r_trig    <= n_trig;
        r_tidx    <= n_tidx;
        r_pos     <= n_pos;
        r_sl      <= n_sl;
        r_sr      <= n_sr;
        r_ev      <= n_ev;
        r_dv_num  <= n_dv_num;
        r_dv_den  <= n_dv_den;
        r_dv_rem  <= n_dv_rem;
        r_out_l   <= n_out_l;
        r_out_r   <= n_out_r;
        r_out_ev  <= n_out_ev;
        r_out_len <= n_out_len;
    end

    // master position stays inside the loop
    `MAL_CHK_NOW(a_mpos_in_loop, r_ml != '0, r_mpos < r_ml)
    // once set, the master loop length is never dropped
    `MAL_CHK_NEXT(a_ml_sticky, r_ml != '0, r_ml != '0)
    // the store is written only by the wipe and the write pass
    `MAL_CHK_NOW(a_store_write, c_we, (r_state == S_CLEAR) || (r_state == S_REC_WR))
    // an accepted transfer is decoded in the next cycle
    `MAL_CHK_NEXT(a_accept_decode, s_axis_tvalid && s_axis_tready, r_state == S_CMD)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the stereo multitrack looper
// depends on mal_pkg and multitrack_audio_looper; a scoreboard class predicts every result
`default_nettype none

module tb_top;
    import mal_pkg::*;

    localparam int NTRK    = 8;
    localparam int NSMP    = 64;      // small store keeps wipes short
    localparam int NITEMS  = 700;
    localparam int WD_MAX  = 20000;   // idle cycles before the watchdog fires
    localparam int SMAXV   = 8388607;
    localparam int SMINV   = -8388608;

    typedef struct packed {
        logic [2:0]  fn;
        logic [2:0]  trk;
        logic [23:0] left;
        logic [23:0] right;
        logic        trig;
        logic [19:0] tidx;
    } t_item;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic [1:0]  ev;
        logic [18:0] len;
        logic [4:0]  pad;
    } t_mix;

    class looper_scoreboard;
        bit [47:0]   store [NTRK][NSMP];
        bit          present [NTRK];
        bit          rec [NTRK];
        bit          play [NTRK];
        int unsigned wpos [NTRK];
        int unsigned rpos [NTRK];
        int unsigned rcnt [NTRK];
        int unsigned mlen, mpos, mtrk;
        t_mix        pending [$];
        int          errors;
        int          n_checked;
        int          n_stops;

        function new();
            errors = 0; n_checked = 0; n_stops = 0;
            mlen = 0; mpos = 0; mtrk = 0;
            for (int k = 0; k < NTRK; k++) begin
                present[k] = 0; rec[k] = 0; play[k] = 0;
                wpos[k] = 0; rpos[k] = 0; rcnt[k] = 0;
                wipe(k);
            end
        endfunction

        function void wipe(int k);
            for (int i = 0; i < NSMP; i++) store[k][i] = '0;
        endfunction

        function bit end_rec(int k);
            int unsigned wp;
            wp = wpos[k];
            rec[k] = 0;
            if (mlen == 0) begin
                if (wp == 0) return 0;
                mtrk = k;
                mlen = wp;
                rcnt[k] = wp;
            end else begin
                if (wp == 0 && rcnt[k] == 0) return 0;
                rcnt[k] = (wp < mlen) ? wp : mlen;
            end
            return 1;
        endfunction

        function void begin_play(int k);
            play[k] = 1;
            rpos[k] = (mlen > 0) ? mpos % mlen : 0;
        endfunction

        function void begin_rec(int k, bit trig, int unsigned tidx);
            rec[k] = 1;
            play[k] = 0;
            rcnt[k] = 0;
            if (mlen > 0 && present[mtrk] && play[mtrk])
                wpos[k] = mpos;
            else if (trig)
                wpos[k] = (tidx > NSMP - 1) ? NSMP - 1 : tidx;
            else begin
                rpos[k] = 0;
                wpos[k] = 0;
            end
            wipe(k);
        endfunction

        function logic [23:0] clip(longint v);
            if (v > SMAXV) v = SMAXV;
            if (v < SMINV) v = SMINV;
            return v[23:0];
        endfunction

        // work out the result of one accepted input transfer
        function void note_input(t_item it);
            t_mix        r;
            longint      sl, sr;
            int unsigned pos, len, idx;
            int          k;
            r = '0;
            if (it.fn == FN_SAMPLE) begin
                sl = longint'($signed(it.left));
                sr = longint'($signed(it.right));
                for (k = 0; k < NTRK; k++) begin
                    if (!present[k] || !rec[k]) continue;
                    if (mlen > 0) begin
                        pos = wpos[k] % mlen;
                        len = mlen;
                        if (pos < NSMP) store[k][pos] = {it.right, it.left};
                        wpos[k] = (pos + 1) % mlen;
                    end else begin
                        len = NSMP;
                        if (wpos[k] < NSMP) begin
                            store[k][wpos[k]] = {it.right, it.left};
                            wpos[k]++;
                        end
                    end
                    if (rcnt[k] != 32'hFFFF_FFFF) rcnt[k]++;
                    if (rcnt[k] >= len) begin
                        if (end_rec(k)) begin
                            r.ev = EV_STOPPED;
                            n_stops++;
                        end
                        begin_play(k);
                    end
                end
                for (k = 0; k < NTRK; k++) begin
                    if (!present[k] || !play[k]) continue;
                    if (mlen > 0) len = mlen;
                    else len = (rcnt[k] > 0) ? rcnt[k] : NSMP;
                    idx = rpos[k] % NSMP;
                    sl += longint'($signed(store[k][idx][23:0]));
                    sr += longint'($signed(store[k][idx][47:24]));
                    rpos[k] = (idx + 1) % len;
                end
                if (mlen > 0) mpos = (mpos + 1) % mlen;
                r.left  = clip(sl);
                r.right = clip(sr);
            end else if (it.fn == FN_ADD) begin
                present[it.trk] = 1;
                rec[it.trk] = 0; play[it.trk] = 0;
                wpos[it.trk] = 0; rpos[it.trk] = 0; rcnt[it.trk] = 0;
                wipe(it.trk);
            end else if (present[it.trk]) begin
                case (it.fn)
                    FN_RECORD: begin
                        begin_rec(it.trk, it.trig, it.tidx);
                        r.ev = EV_STARTED;
                    end
                    FN_STOP_REC: begin
                        if (rec[it.trk] && end_rec(it.trk)) begin
                            r.ev = EV_STOPPED;
                            n_stops++;
                        end
                    end
                    FN_PLAY:      begin_play(it.trk);
                    FN_STOP_PLAY: play[it.trk] = 0;
                    FN_CLEAR:     wipe(it.trk);
                    default: ;
                endcase
            end
            r.len = mlen[18:0];
            pending.push_back(r);
        endfunction

        // compare one output transfer with the oldest prediction
        function void check_output(t_mix got);
            t_mix want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.left !== want.left)
                $display("%0t: out_left expected %h actual %h", $time, want.left, got.left);
            if (got.right !== want.right)
                $display("%0t: out_right expected %h actual %h", $time, want.right, got.right);
            if (got.ev !== want.ev)
                $display("%0t: event expected %0d actual %0d", $time, want.ev, got.ev);
            if (got.len !== want.len)
                $display("%0t: loop_length expected %0d actual %0d", $time, want.len, got.len);
            if (got.pad !== 5'd0)
                $display("%0t: padding expected 0 actual %h", $time, got.pad);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire logic   s_axis_tready;
    logic [71:0] s_axis_tdata;   // track, in_left, in_right, trigger_valid, trigger_index
    logic [2:0]  s_axis_tuser;   // func
    wire logic   m_axis_tvalid;
    logic        m_axis_tready;
    wire [71:0]  m_axis_tdata;   // out_left, out_right, loop_length, zero pad
    wire [1:0]   m_axis_tuser;   // event_res

    looper_scoreboard sb;
    int  idle_cycles = 0;
    int  n_sent;
    bit  src_done;
    bit  squeezed;

    multitrack_audio_looper #(.TRACKS(NTRK), .MAX_SAMPLES(NSMP)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_MAX) begin
                $display("%0t: watchdog expired", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // random sample value, extremes now and then for saturation
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic t_item make_item(logic [2:0] fn, logic [2:0] trk);
        t_item it;
        it.fn    = fn;
        it.trk   = trk;
        it.left  = rand_sample();
        it.right = rand_sample();
        it.trig  = 1'($urandom_range(0, 1));
        it.tidx  = $urandom_range(0, 3) == 0 ? 20'($urandom()) : 20'($urandom_range(0, NSMP + 2));
        return it;
    endfunction

    // drive one item after a random gap, hold until the transfer happens
    task automatic send_item(t_item it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.fn;
        s_axis_tdata  = {it.tidx, it.trig, it.right, it.left, it.trk};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(it);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_cmd(logic [2:0] fn, logic [2:0] trk);
        send_item(make_item(fn, trk));
    endtask

    task automatic send_samples(int n);
        for (int i = 0; i < n; i++) send_cmd(FN_SAMPLE, 3'($urandom()));
    endtask

    // receiver: random hold-offs, one long squeeze so the block backs up
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!squeezed && sb.n_checked == 120) begin
                squeezed = 1;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    m_axis_tready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_output({m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tuser,
                             m_axis_tdata[66:48], m_axis_tdata[71:67]});
        end
    end

    initial begin
        int r;
        sb = new();
        n_sent        = 0;
        src_done      = 0;
        squeezed      = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_SAMPLE;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: commands on absent tracks, empty stop, unknown func
        send_cmd(FN_RECORD, 3'd7);
        send_cmd(3'd7, 3'd0);
        send_cmd(FN_ADD, 3'd0);
        send_cmd(FN_ADD, 3'd7);
        send_cmd(FN_STOP_REC, 3'd0);              // not recording
        send_item('{FN_RECORD, 3'd0, 24'd0, 24'd0, 1'b0, 20'd0});
        send_cmd(FN_STOP_REC, 3'd0);              // empty stop, no master
        send_item('{FN_RECORD, 3'd7, 24'd0, 24'd0, 1'b1, 20'hFFFFF}); // clamped trigger
        send_item('{FN_RECORD, 3'd0, 24'd0, 24'd0, 1'b0, 20'd0});
        send_samples(6);
        send_cmd(FN_STOP_REC, 3'd0);              // sets master length
        send_cmd(FN_PLAY, 3'd0);
        send_item('{FN_SAMPLE, 3'd0, 24'h7FFFFF, 24'h800000, 1'b0, 20'd0});
        send_cmd(FN_STOP_PLAY, 3'd7);
        send_cmd(FN_CLEAR, 3'd0);
        send_cmd(FN_ADD, 3'd0);                   // re-add resets track

        // random part: recording sessions mixed with noise
        while (n_sent < NITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                logic [2:0] t;
                t = 3'($urandom());
                send_cmd(FN_ADD, t);
                send_cmd(FN_RECORD, t);
                send_samples($urandom_range(1, 12));
                if ($urandom_range(0, 2) != 0) send_cmd(FN_STOP_REC, t);
                send_cmd(FN_PLAY, t);
            end else if (r < 85) begin
                send_samples($urandom_range(1, 8));
            end else begin
                send_cmd(3'($urandom_range(1, 7)), 3'($urandom()));
            end
        end
        src_done = 1;
        s_axis_tvalid = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d items, %0d results checked, %0d record stops, loop length %0d",
                 n_sent, sb.n_checked, sb.n_stops, sb.mlen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
